// ----- design/mmf_pkg.sv -----
// shared types, constants and register codes for the mask mirror fill unit
package mmf_pkg;

   localparam int MMF_MAX_WIDTH  = 1024;
   localparam int MMF_MAX_HEIGHT = 1024;

   localparam int MMF_PIX_W  = 8;
   localparam int MMF_LEFT_W = 10;
   localparam int MMF_CFG_W  = 11;
   localparam int MMF_TOP_W  = 11;
   localparam int MMF_CSR_AW = 2;

   localparam logic [MMF_PIX_W-1:0] MMF_PIXEL_ON  = 8'd255;
   localparam logic [MMF_PIX_W-1:0] MMF_PIXEL_OFF = 8'd0;
   localparam logic [MMF_TOP_W-1:0] MMF_TOP_NONE  = 11'h7FF;

   localparam logic [MMF_LEFT_W-1:0] MMF_LEFT_COL_RST   = 10'd0;
   localparam logic [MMF_CFG_W-1:0]  MMF_MID_COL_RST    = 11'd512;
   localparam logic [MMF_CFG_W-1:0]  MMF_MIRROR_SUM_RST = 11'd1023;
   localparam logic                  MMF_FILL_GAPS_RST  = 1'b1;

   typedef enum logic [MMF_CSR_AW-1:0] {
      CSR_LEFT_COL   = 2'd0,
      CSR_MID_COL    = 2'd1,
      CSR_MIRROR_SUM = 2'd2,
      CSR_FILL_GAPS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MMF_LEFT_W-1:0] left_col;
      logic [MMF_CFG_W-1:0]  mid_col;
      logic [MMF_CFG_W-1:0]  mirror_sum;
      logic                  fill_gaps;
   } cfg_type;

   // per-request result info handed from the row control to the output stage
   typedef struct packed {
      logic                 mem_ok;
      logic                 fill_hit;
      logic [MMF_TOP_W-1:0] top_row;
      logic                 frame_done;
   } row_info_type;

endpackage

// ----- design/mmf_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
module mmf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- design/mmf_csr.sv -----
// configuration registers of the mask mirror fill unit
module mmf_csr
   import mmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [MMF_CSR_AW-1:0] csr_addr,
   input  logic [MMF_CFG_W-1:0]  csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_LEFT_COL: begin
               cfg_in.left_col = csr_wdata[MMF_LEFT_W-1:0];
            end
            CSR_MID_COL: begin
               cfg_in.mid_col = csr_wdata;
            end
            CSR_MIRROR_SUM: begin
               cfg_in.mirror_sum = csr_wdata;
            end
            CSR_FILL_GAPS: begin
               cfg_in.fill_gaps = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_col   <= MMF_LEFT_COL_RST;
         cfg_ff.mid_col    <= MMF_MID_COL_RST;
         cfg_ff.mirror_sum <= MMF_MIRROR_SUM_RST;
         cfg_ff.fill_gaps  <= MMF_FILL_GAPS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/mmf_row_ctrl.sv -----
// column and row tracking, line buffer addressing and per-row snapshot
module mmf_row_ctrl
   import mmf_pkg::*;
#(
   parameter int MAX_WIDTH  = MMF_MAX_WIDTH,
   parameter int MAX_HEIGHT = MMF_MAX_HEIGHT,
   localparam int IW = $clog2(MAX_WIDTH),
   localparam int AW = IW + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 accept,
   input  logic [MMF_PIX_W-1:0] pixel_in,
   input  logic                 row_end,
   input  logic                 frame_end,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic                 wr_data,
   output logic [AW-1:0]        rd_addr,
   output row_info_type         info
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DW = (CW > MMF_CFG_W) ? CW : MMF_CFG_W;

   // live row state
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          bank_ff, bank_in;
   logic          have_first_ff, have_first_in;
   logic [IW-1:0] first_ff, first_in;
   logic          have_top_ff, have_top_in;
   logic [RW-1:0] top_ff, top_in;

   // settings of the row that was just closed, used while it is read back
   logic [MMF_LEFT_W-1:0] p_left_ff, p_left_in;
   logic [MMF_CFG_W-1:0]  p_mid_ff, p_mid_in;
   logic [MMF_CFG_W-1:0]  p_sum_ff, p_sum_in;
   logic [CW-1:0]         p_valid_ff, p_valid_in;
   logic                  p_fill_ok_ff, p_fill_ok_in;
   logic [IW-1:0]         p_fill_lo_ff, p_fill_lo_in;
   logic [DW-1:0]         p_fill_hi_ff, p_fill_hi_in;

   logic          cin;
   logic [DW-1:0] cx;
   logic          inwin;
   logic          set;
   logic          direct;
   logic [DW:0]   diff;
   logic [DW-1:0] src;
   logic          src_ok;
   logic          next_have_first;
   logic [IW-1:0] next_first;
   logic          next_have_top;
   logic [RW-1:0] next_top;
   logic [RW+MMF_TOP_W-1:0] top_wide;
   logic          line_end;

   always_comb begin
      cin   = col_ff < CW'(MAX_WIDTH);
      cx    = DW'(col_ff);
      inwin = (cx >= DW'(cfg.left_col)) && (cx < DW'(cfg.mid_col)) && cin;
      set   = (pixel_in != '0) && inwin;

      // left of the axis the source is the column itself, right of it the mirror
      direct = cx < DW'(p_mid_ff);
      diff   = {1'b0, DW'(p_sum_ff)} - {1'b0, cx};
      src    = direct ? cx : diff[DW-1:0];
      src_ok = (src >= DW'(p_left_ff)) && (src < DW'(p_mid_ff))
               && (src < DW'(p_valid_ff));

      next_have_first = have_first_ff || set;
      next_first      = have_first_ff ? first_ff : col_ff[IW-1:0];
      next_have_top   = have_top_ff || set;
      next_top        = have_top_ff ? top_ff : row_ff;
      top_wide        = {{MMF_TOP_W{1'b0}}, next_top};
      line_end        = row_end || frame_end;

      info.mem_ok     = cin && src_ok && (direct || !diff[DW]);
      info.fill_hit   = cin && p_fill_ok_ff && (cx >= DW'(p_fill_lo_ff))
                        && (cx <= p_fill_hi_ff);
      info.top_row    = next_have_top ? top_wide[MMF_TOP_W-1:0] : MMF_TOP_NONE;
      info.frame_done = frame_end;

      wr_en   = accept && cin;
      wr_addr = {bank_ff, col_ff[IW-1:0]};
      wr_data = set;
      rd_addr = {~bank_ff, src[IW-1:0]};
   end

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      bank_in       = bank_ff;
      have_first_in = have_first_ff;
      first_in      = first_ff;
      have_top_in   = have_top_ff;
      top_in        = top_ff;
      p_left_in     = p_left_ff;
      p_mid_in      = p_mid_ff;
      p_sum_in      = p_sum_ff;
      p_valid_in    = p_valid_ff;
      p_fill_ok_in  = p_fill_ok_ff;
      p_fill_lo_in  = p_fill_lo_ff;
      p_fill_hi_in  = p_fill_hi_ff;
      if (accept) begin
         have_first_in = next_have_first;
         first_in      = next_first;
         have_top_in   = next_have_top;
         top_in        = next_top;
         if (line_end) begin
            p_left_in    = cfg.left_col;
            p_mid_in     = cfg.mid_col;
            p_sum_in     = cfg.mirror_sum;
            p_valid_in   = cin ? (col_ff + CW'(1)) : col_ff;
            p_fill_ok_in = cfg.fill_gaps && next_have_first
                           && (DW'(cfg.mirror_sum) >= DW'(next_first));
            p_fill_lo_in = next_first;
            p_fill_hi_in = DW'(cfg.mirror_sum) - DW'(next_first);
            col_in        = '0;
            bank_in       = ~bank_ff;
            have_first_in = 1'b0;
            if (frame_end) begin
               row_in      = '0;
               have_top_in = 1'b0;
            end else if (row_ff < RW'(MAX_HEIGHT - 1)) begin
               row_in = row_ff + RW'(1);
            end
         end else if (cin) begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         bank_ff       <= 1'b0;
         have_first_ff <= 1'b0;
         have_top_ff   <= 1'b0;
         p_left_ff     <= MMF_LEFT_COL_RST;
         p_mid_ff      <= MMF_MID_COL_RST;
         p_sum_ff      <= MMF_MIRROR_SUM_RST;
         p_valid_ff    <= '0;
         p_fill_ok_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         bank_ff       <= bank_in;
         have_first_ff <= have_first_in;
         have_top_ff   <= have_top_in;
         p_left_ff     <= p_left_in;
         p_mid_ff      <= p_mid_in;
         p_sum_ff      <= p_sum_in;
         p_valid_ff    <= p_valid_in;
         p_fill_ok_ff  <= p_fill_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      top_ff       <= top_in;
      p_fill_lo_ff <= p_fill_lo_in;
      p_fill_hi_ff <= p_fill_hi_in;
   end

endmodule

// ----- design/mmf_out_stage.sv -----
// line buffer read stage and result register with handshake control
module mmf_out_stage
   import mmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  row_info_type         info,
   input  logic                 line_bit,
   output logic                 take,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [MMF_PIX_W-1:0] pixel_out,
   output logic [MMF_TOP_W-1:0] top_row,
   output logic                 frame_done
);

   logic                 s1_valid_ff, s1_valid_in;
   row_info_type         s1_info_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [MMF_PIX_W-1:0] out_pixel_ff;
   logic [MMF_TOP_W-1:0] out_top_ff;
   logic                 out_done_ff;
   logic                 out_load;

   always_comb begin
      out_load     = s1_valid_ff && (!out_valid_ff || rsp_tready);
      take         = !s1_valid_ff || out_load;
      s1_valid_in  = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (out_load) begin
         // line buffer data arrives with the stage-one register
         out_pixel_ff <= ((s1_info_ff.mem_ok && line_bit) || s1_info_ff.fill_hit)
                         ? MMF_PIXEL_ON : MMF_PIXEL_OFF;
         out_top_ff   <= s1_info_ff.top_row;
         out_done_ff  <= s1_info_ff.frame_done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign pixel_out  = out_pixel_ff;
   assign top_row    = out_top_ff;
   assign frame_done = out_done_ff;

endmodule

// ----- design/mask_mirror_fill_unit.sv -----
// top level of the mask mirror fill unit
// Takes one mask pixel per cycle in raster order, sustained while rsp_tready is
// high, and returns one result per request through the stage-one and result
// registers. The mirrored pixel returned for a column is from the previous row:
// a line buffer of two banks of MAX_WIDTH bits each, toggled at every row end,
// takes one write (current row) and one read (previous row, direct or mirror
// column) per cycle, and that single read port sets the rate. The buffer is
// never cleared; only entries written during the previous row are used, so
// the unit is ready right after reset. Configuration registers are sampled
// at each row end for the row being read back.
module mask_mirror_fill_unit
   import mmf_pkg::*;
#(
   parameter int MAX_WIDTH  = MMF_MAX_WIDTH,
   parameter int MAX_HEIGHT = MMF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // pixel_in[7:0]
   input  logic                  req_tlast,   // row_end
   input  logic                  req_tuser,   // frame_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // pixel_out[7:0], top_row[18:8], zeros
   output logic                  rsp_tlast,   // frame_done
   input  logic                  csr_we,
   input  logic [MMF_CSR_AW-1:0] csr_addr,
   input  logic [MMF_CFG_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_WIDTH);
   localparam int AW = IW + 1;

   cfg_type              cfg;
   row_info_type         info;
   logic                 accept;
   logic                 take;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 wr_data;
   logic [AW-1:0]        rd_addr;
   logic                 line_bit;
   logic [MMF_PIX_W-1:0] pixel_out;
   logic [MMF_TOP_W-1:0] top_row;

   assign req_tready = take;
   assign accept     = req_tvalid && take;

   mmf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mmf_row_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_row_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .pixel_in  (req_tdata),
      .row_end   (req_tlast),
      .frame_end (req_tuser),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   mmf_ram #(
      .WIDTH (1),
      .DEPTH (2 ** AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (line_bit)
   );

   mmf_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .info       (info),
      .line_bit   (line_bit),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_out  (pixel_out),
      .top_row    (top_row),
      .frame_done (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, top_row, pixel_out};

endmodule
